[sv/wavs_pkg.sv]
`timescale 1ns / 1ps
package wavs_pkg;

   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_FRAME  = 2'd1;
   localparam logic [1:0] KIND_DONE   = 2'd2;
   localparam logic [1:0] KIND_ERROR  = 2'd3;

   localparam logic [2:0] ERR_NOT_RIFF    = 3'd0;
   localparam logic [2:0] ERR_NOT_WAVE    = 3'd1;
   localparam logic [2:0] ERR_NON_PCM     = 3'd2;
   localparam logic [2:0] ERR_NOT_16BIT   = 3'd3;
   localparam logic [2:0] ERR_MISSING     = 3'd4;
   localparam logic [2:0] ERR_ZERO_CHANS  = 3'd5;

   localparam logic [31:0] TAG_RIFF = 32'h46464952;
   localparam logic [31:0] TAG_WAVE = 32'h45564157;
   localparam logic [31:0] TAG_FMT  = 32'h20746d66;
   localparam logic [31:0] TAG_DATA = 32'h61746164;
   localparam logic [4:0]  FMT_BODY_BYTES = 5'd16;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } in_item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] left;
      logic [15:0] right;
      logic [31:0] sample_rate;
      logic [15:0] channel_count;
      logic [30:0] frame_count;
      logic [2:0]  error_code;
      logic        last;
   } out_item_type;

   // What the front end decided for one byte: up to two results.
   typedef struct packed {
      logic         two;
      out_item_type first;
      out_item_type second;
   } work_type;

   typedef enum logic [10:0] {
      PH_RIFF     = 11'b00000000001,
      PH_RSIZE    = 11'b00000000010,
      PH_WAVE     = 11'b00000000100,
      PH_CID      = 11'b00000001000,
      PH_SZ_FMT   = 11'b00000010000,
      PH_SZ_DATA  = 11'b00000100000,
      PH_SZ_OTHER = 11'b00001000000,
      PH_FMT      = 11'b00010000000,
      PH_SKIP     = 11'b00100000000,
      PH_SAMPLES  = 11'b01000000000,
      PH_HALT     = 11'b10000000000
   } phase_type;

   function automatic out_item_type make_item(logic [1:0] kind, logic [15:0] l,
         logic [15:0] r, logic [31:0] rate, logic [15:0] ch, logic [30:0] fr,
         logic [2:0] err);
      out_item_type o;
      o.kind = kind;
      o.left = l;
      o.right = r;
      o.sample_rate = rate;
      o.channel_count = ch;
      o.frame_count = fr;
      o.error_code = err;
      o.last = 1'b0;
      return o;
   endfunction

endpackage

[sv/wavs_if.sv]
`timescale 1ns / 1ps
interface wavs_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[sv/wav_pcm16_stream_to_stereo.sv]
`timescale 1ns / 1ps
// A byte's results are written into the queue when the byte is accepted and are then
// loaded into the rsp register whenever it is free. Throughput: one byte per cycle
// while the queue has space; a byte giving two results sends them out in turn.
// The parser state advances once per accepted byte; a four-entry queue absorbs stalls.
// Reset is synchronous and active high; it clears the parser, queue and output valid.
module wav_pcm16_stream_to_stereo import wavs_pkg::*; (
   input logic clock,
   input logic reset,
   wavs_if.sink   req,
   wavs_if.source rsp
);

   logic     fv, qspace, qvalid, qpop, fready;
   work_type fwork, qwork;

   assign fready = qspace;

   wavs_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_item (req.payload),
      .work_valid (fv), .work_ready (fready), .work (fwork)
   );

   wavs_queue u_queue (
      .clock, .reset,
      .push (fv), .push_item (fwork), .space (qspace),
      .pop_valid (qvalid), .pop (qpop), .pop_item (qwork)
   );

   wavs_back u_back (
      .clock, .reset,
      .work_valid (qvalid), .work (qwork), .work_pop (qpop),
      .out_valid (rsp.valid), .out_ready (rsp.ready), .out_item (rsp.payload)
   );

endmodule

[sv/wavs_front.sv]
`timescale 1ns / 1ps
module wavs_front import wavs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  in_item_type in_item,
   output logic        work_valid,
   input  logic        work_ready,
   output work_type    work
);

   phase_type   phase_ff, phase_in;
   logic [4:0]  idx_ff, idx_in;
   logic [31:0] shift_ff, shift_in;
   logic [31:0] chunk_ff, chunk_in;
   logic [15:0] fmt_ff, fmt_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] chans_ff, chans_in;
   logic [15:0] depth_ff, depth_in;
   logic        seen_ff, seen_in;
   logic [31:0] dleft_ff, dleft_in;
   logic [7:0]  low_ff, low_in;
   logic [15:0] chidx_ff, chidx_in;
   logic [15:0] lhold_ff, lhold_in;
   logic [30:0] frames_ff, frames_in;

   logic [4:0]  idx_inc;
   logic [31:0] shifted;
   logic [15:0] smp;
   logic [1:0]  n;
   out_item_type r0, r1, res;
   logic        fire;

   assign in_ready   = work_ready;
   assign fire       = in_valid && in_ready;
   assign idx_inc    = idx_ff + 5'd1;
   assign shifted    = {in_item.data_byte, shift_ff[31:8]};
   assign smp        = {in_item.data_byte, low_ff};

   always_comb begin
      phase_in = phase_ff; idx_in = idx_ff; shift_in = shift_ff; chunk_in = chunk_ff;
      fmt_in = fmt_ff; rate_in = rate_ff; chans_in = chans_ff; depth_in = depth_ff;
      seen_in = seen_ff; dleft_in = dleft_ff; low_in = low_ff; chidx_in = chidx_ff;
      lhold_in = lhold_ff; frames_in = frames_ff;
      n = 2'd0; r0 = '0; r1 = '0; res = '0;
      unique case (phase_ff)
         PH_RIFF, PH_RSIZE, PH_WAVE, PH_CID, PH_SZ_FMT, PH_SZ_OTHER, PH_SZ_DATA: begin
            shift_in = shifted;
            idx_in = idx_inc;
            if (idx_inc >= 5'd4) begin
               idx_in = '0;
               unique case (phase_ff)
                  PH_RIFF: begin
                     if (shifted == TAG_RIFF) phase_in = PH_RSIZE;
                     else begin
                        phase_in = PH_HALT; n = 2'd1;
                        r0 = make_item(KIND_ERROR, '0, '0, '0, '0, '0, ERR_NOT_RIFF);
                     end
                  end
                  PH_RSIZE: phase_in = PH_WAVE;
                  PH_WAVE: begin
                     if (shifted == TAG_WAVE) phase_in = PH_CID;
                     else begin
                        phase_in = PH_HALT; n = 2'd1;
                        r0 = make_item(KIND_ERROR, '0, '0, '0, '0, '0, ERR_NOT_WAVE);
                     end
                  end
                  PH_CID: begin
                     if (shifted == TAG_FMT) phase_in = PH_SZ_FMT;
                     else if (shifted == TAG_DATA) phase_in = PH_SZ_DATA;
                     else phase_in = PH_SZ_OTHER;
                  end
                  PH_SZ_FMT: begin
                     chunk_in = shifted;
                     fmt_in = '0; chans_in = '0; rate_in = '0; depth_in = '0;
                     phase_in = PH_FMT;
                  end
                  PH_SZ_OTHER: begin
                     chunk_in = shifted;
                     phase_in = (shifted == '0) ? PH_CID : PH_SKIP;
                  end
                  default: begin
                     phase_in = PH_HALT; n = 2'd1;
                     if (!seen_ff)
                        r0 = make_item(KIND_ERROR, '0, '0, '0, '0, '0, ERR_MISSING);
                     else if (depth_ff != 16'd16)
                        r0 = make_item(KIND_ERROR, '0, '0, '0, '0, '0, ERR_NOT_16BIT);
                     else if (chans_ff == '0)
                        r0 = make_item(KIND_ERROR, '0, '0, '0, '0, '0, ERR_ZERO_CHANS);
                     else begin
                        dleft_in = shifted; chidx_in = '0; phase_in = PH_SAMPLES;
                        r0 = make_item(KIND_HEADER, '0, '0, rate_ff, chans_ff, '0, '0);
                        if (shifted == '0) begin
                           phase_in = PH_HALT; n = 2'd2;
                           r1 = make_item(KIND_DONE, '0, '0, '0, '0, frames_ff, '0);
                        end
                     end
                  end
               endcase
            end
         end
         PH_FMT: begin
            unique case (idx_ff)
               5'd0: fmt_in[7:0] = in_item.data_byte;
               5'd1: fmt_in[15:8] = in_item.data_byte;
               5'd2: chans_in[7:0] = in_item.data_byte;
               5'd3: chans_in[15:8] = in_item.data_byte;
               5'd4: rate_in[7:0] = in_item.data_byte;
               5'd5: rate_in[15:8] = in_item.data_byte;
               5'd6: rate_in[23:16] = in_item.data_byte;
               5'd7: rate_in[31:24] = in_item.data_byte;
               5'd14: depth_in[7:0] = in_item.data_byte;
               5'd15: depth_in[15:8] = in_item.data_byte;
               default: ;
            endcase
            idx_in = idx_inc;
            if (idx_inc >= FMT_BODY_BYTES) begin
               idx_in = '0;
               if (fmt_ff != 16'd1) begin
                  phase_in = PH_HALT; n = 2'd1;
                  r0 = make_item(KIND_ERROR, '0, '0, '0, '0, '0, ERR_NON_PCM);
               end else begin
                  seen_in = 1'b1;
                  if (chunk_ff > 32'd16) begin
                     chunk_in = chunk_ff - 32'd16; phase_in = PH_SKIP;
                  end else phase_in = PH_CID;
               end
            end
         end
         PH_SKIP: begin
            chunk_in = chunk_ff - 32'd1;
            if (chunk_in == '0) phase_in = PH_CID;
         end
         PH_SAMPLES: begin
            dleft_in = dleft_ff - 32'd1;
            if (!idx_ff[0]) begin
               low_in = in_item.data_byte; idx_in = 5'd1;
            end else begin
               idx_in = '0;
               if (chans_ff == 16'd1) begin
                  frames_in = frames_ff + 31'd1; n = 2'd1;
                  r0 = make_item(KIND_FRAME, smp, smp, '0, '0, '0, '0);
               end else begin
                  if (chidx_ff == '0) lhold_in = smp;
                  else if (chidx_ff == 16'd1) shift_in = {16'd0, smp};
                  if ({1'b0, chidx_ff} + 17'd1 >= {1'b0, chans_ff}) begin
                     chidx_in = '0; frames_in = frames_ff + 31'd1; n = 2'd1;
                     r0 = make_item(KIND_FRAME, lhold_in, shift_in[15:0], '0, '0, '0, '0);
                  end else chidx_in = chidx_ff + 16'd1;
               end
            end
            if (dleft_in == '0) begin
               phase_in = PH_HALT;
               res = make_item(KIND_DONE, '0, '0, '0, '0, frames_in, '0);
               if (n == 2'd0) r0 = res; else r1 = res;
               n = n + 2'd1;
            end
         end
         default: ;
      endcase
      if (in_item.end_of_file) begin
         res = '0;
         if (phase_in == PH_RIFF)
            res = make_item(KIND_ERROR, '0, '0, '0, '0, '0, ERR_NOT_RIFF);
         else if (phase_in == PH_RSIZE || phase_in == PH_WAVE)
            res = make_item(KIND_ERROR, '0, '0, '0, '0, '0, ERR_NOT_WAVE);
         else if (phase_in == PH_SAMPLES)
            res = make_item(KIND_DONE, '0, '0, '0, '0, frames_in, '0);
         else if (phase_in != PH_HALT)
            res = make_item(KIND_ERROR, '0, '0, '0, '0, '0, ERR_MISSING);
         if (phase_in != PH_HALT) begin
            if (n == 2'd0) r0 = res; else r1 = res;
            n = n + 2'd1;
         end
         phase_in = PH_RIFF; idx_in = '0; shift_in = '0; chunk_in = '0; fmt_in = '0;
         rate_in = '0; chans_in = '0; depth_in = '0; seen_in = 1'b0; dleft_in = '0;
         low_in = '0; chidx_in = '0; lhold_in = '0; frames_in = '0;
      end
      if (n == 2'd1) r0.last = 1'b1;
      if (n == 2'd2) r1.last = 1'b1;
   end

   assign work_valid  = fire && (n != 2'd0);
   assign work.two    = (n == 2'd2);
   assign work.first  = r0;
   assign work.second = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF; idx_ff <= '0; shift_ff <= '0; chunk_ff <= '0;
         fmt_ff <= '0; rate_ff <= '0; chans_ff <= '0; depth_ff <= '0; seen_ff <= 1'b0;
         dleft_ff <= '0; low_ff <= '0; chidx_ff <= '0; lhold_ff <= '0; frames_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in; idx_ff <= idx_in; shift_ff <= shift_in;
         chunk_ff <= chunk_in; fmt_ff <= fmt_in; rate_ff <= rate_in;
         chans_ff <= chans_in; depth_ff <= depth_in; seen_ff <= seen_in;
         dleft_ff <= dleft_in; low_ff <= low_in; chidx_ff <= chidx_in;
         lhold_ff <= lhold_in; frames_ff <= frames_in;
      end
   end

`ifndef SYNTH
   a_halt_stays: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HALT && fire && !in_item.end_of_file) |=> phase_ff == PH_HALT)
      else $error("halt phase left without end of file");
   a_eof_resets: assert property (@(posedge clock) disable iff (reset)
      (fire && in_item.end_of_file) |=> (phase_ff == PH_RIFF && frames_ff == '0))
      else $error("end of file did not restart the parser");
   a_fmt_index: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_FMT |-> idx_ff < FMT_BODY_BYTES)
      else $error("fmt byte index out of range");
`endif

endmodule

[sv/wavs_queue.sv]
`timescale 1ns / 1ps
module wavs_queue import wavs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  work_type push_item,
   output logic     space,
   output logic     pop_valid,
   input  logic     pop,
   output work_type pop_item
);

   work_type              slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ff, rd_ff;
   logic [QUEUE_AW:0]     count_ff;

   assign space     = count_ff < (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_item  = slots_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) slots_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (QUEUE_AW + 1)'(push) - (QUEUE_AW + 1)'(pop);
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (space || pop))
      else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue underflow");
`endif

endmodule

[sv/wavs_back.sv]
`timescale 1ns / 1ps
module wavs_back import wavs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         work_valid,
   input  work_type     work,
   output logic         work_pop,
   output logic         out_valid,
   input  logic         out_ready,
   output out_item_type out_item
);

   logic         half_ff;
   logic         valid_ff;
   out_item_type item_ff;
   logic         load;

   // The output register refills from waiting work whenever it is empty or being drained.
   assign load      = work_valid && (!valid_ff || out_ready);
   assign work_pop  = load && (!work.two || half_ff);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (load) item_ff <= half_ff ? work.second : work.first;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0; half_ff <= 1'b0;
      end else begin
         if (load) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
         if (load) half_ff <= work.two && !half_ff;
      end
   end

`ifndef SYNTH
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> $stable(item_ff))
      else $error("result changed while stalled");
   a_half_needs_two: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> (work_valid && work.two))
      else $error("second half pending without a pair");
`endif

endmodule

[bench/wavs_checker.sv]
`timescale 1ns / 1ps
module wavs_checker import wavs_pkg::*; (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input in_item_type req_payload,
   input logic rsp_valid,
   input logic rsp_ready,
   input out_item_type rsp_payload,
   output int fail_count,
   output int pending_count
);

   out_item_type expected_results[$];

   // Parser state mirrored from the file format.
   phase_type   phase;
   logic [4:0]  byte_idx;
   logic [31:0] shift_word;
   logic [31:0] chunk_left;
   logic [15:0] fmt_code;
   logic [31:0] rate;
   logic [15:0] chans;
   logic [15:0] depth;
   logic        have_fmt;
   logic [31:0] data_left;
   logic [7:0]  low_hold;
   logic [15:0] chan_idx;
   logic [15:0] left_keep;
   logic [30:0] frames;

   out_item_type step_results[$];

   function automatic void clear_parser();
      phase = PH_RIFF;
      byte_idx = '0;
      shift_word = '0;
      chunk_left = '0;
      fmt_code = '0;
      rate = '0;
      chans = '0;
      depth = '0;
      have_fmt = 1'b0;
      data_left = '0;
      low_hold = '0;
      chan_idx = '0;
      left_keep = '0;
      frames = '0;
   endfunction

   function automatic void push(logic [1:0] kind, logic [15:0] l, logic [15:0] r,
         logic [31:0] rt, logic [15:0] ch, logic [30:0] fr, logic [2:0] err);
      out_item_type o;
      o = '0;
      o.kind = kind;
      o.left = l;
      o.right = r;
      o.sample_rate = rt;
      o.channel_count = ch;
      o.frame_count = fr;
      o.error_code = err;
      step_results.push_back(o);
   endfunction

   function automatic void stop_error(logic [2:0] err);
      phase = PH_HALT;
      push(KIND_ERROR, '0, '0, '0, '0, '0, err);
   endfunction

   function automatic void stop_done();
      phase = PH_HALT;
      push(KIND_DONE, '0, '0, '0, '0, frames, '0);
   endfunction

   function automatic logic word_complete(logic [7:0] b);
      shift_word = {b, shift_word[31:8]};
      byte_idx = byte_idx + 5'd1;
      if (byte_idx >= 5'd4) begin
         byte_idx = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void take_sample_byte(logic [7:0] b);
      logic [15:0] s;
      data_left = data_left - 32'd1;
      if (byte_idx[0] == 1'b0) begin
         low_hold = b;
         byte_idx = 5'd1;
      end else begin
         byte_idx = '0;
         s = {b, low_hold};
         if (chans == 16'd1) begin
            frames = frames + 31'd1;
            push(KIND_FRAME, s, s, '0, '0, '0, '0);
         end else begin
            if (chan_idx == 16'd0) left_keep = s;
            else if (chan_idx == 16'd1) shift_word = {16'd0, s};
            if ({16'd0, chan_idx} + 32'd1 >= {16'd0, chans}) begin
               chan_idx = '0;
               frames = frames + 31'd1;
               push(KIND_FRAME, left_keep, shift_word[15:0], '0, '0, '0, '0);
            end else begin
               chan_idx = chan_idx + 16'd1;
            end
         end
      end
      if (data_left == 32'd0) stop_done();
   endfunction

   function automatic void predict_byte(in_item_type item);
      logic [7:0] b;
      int i;
      b = item.data_byte;
      step_results.delete();
      case (phase)
         PH_RIFF: if (word_complete(b)) begin
            if (shift_word == TAG_RIFF) phase = PH_RSIZE;
            else stop_error(ERR_NOT_RIFF);
         end
         PH_RSIZE: if (word_complete(b)) phase = PH_WAVE;
         PH_WAVE: if (word_complete(b)) begin
            if (shift_word == TAG_WAVE) phase = PH_CID;
            else stop_error(ERR_NOT_WAVE);
         end
         PH_CID: if (word_complete(b)) begin
            if (shift_word == TAG_FMT) phase = PH_SZ_FMT;
            else if (shift_word == TAG_DATA) phase = PH_SZ_DATA;
            else phase = PH_SZ_OTHER;
         end
         PH_SZ_FMT: if (word_complete(b)) begin
            chunk_left = shift_word;
            fmt_code = '0;
            chans = '0;
            rate = '0;
            depth = '0;
            phase = PH_FMT;
         end
         PH_SZ_OTHER: if (word_complete(b)) begin
            chunk_left = shift_word;
            phase = (chunk_left == 32'd0) ? PH_CID : PH_SKIP;
         end
         PH_FMT: begin
            i = byte_idx;
            if (i < 2) fmt_code[8*i +: 8] = b;
            else if (i < 4) chans[8*(i-2) +: 8] = b;
            else if (i < 8) rate[8*(i-4) +: 8] = b;
            else if (i >= 14) depth[8*(i-14) +: 8] = b;
            byte_idx = byte_idx + 5'd1;
            if (byte_idx >= FMT_BODY_BYTES) begin
               byte_idx = '0;
               if (fmt_code != 16'd1) begin
                  stop_error(ERR_NON_PCM);
               end else begin
                  have_fmt = 1'b1;
                  if (chunk_left > 32'd16) begin
                     chunk_left = chunk_left - 32'd16;
                     phase = PH_SKIP;
                  end else begin
                     phase = PH_CID;
                  end
               end
            end
         end
         PH_SKIP: begin
            chunk_left = chunk_left - 32'd1;
            if (chunk_left == 32'd0) phase = PH_CID;
         end
         PH_SZ_DATA: if (word_complete(b)) begin
            if (!have_fmt) stop_error(ERR_MISSING);
            else if (depth != 16'd16) stop_error(ERR_NOT_16BIT);
            else if (chans == 16'd0) stop_error(ERR_ZERO_CHANS);
            else begin
               data_left = shift_word;
               chan_idx = '0;
               byte_idx = '0;
               phase = PH_SAMPLES;
               push(KIND_HEADER, '0, '0, rate, chans, '0, '0);
               if (data_left == 32'd0) stop_done();
            end
         end
         PH_SAMPLES: take_sample_byte(b);
         default: ;
      endcase
      if (item.end_of_file) begin
         if (phase == PH_RIFF) stop_error(ERR_NOT_RIFF);
         else if (phase == PH_RSIZE || phase == PH_WAVE) stop_error(ERR_NOT_WAVE);
         else if (phase == PH_SAMPLES) stop_done();
         else if (phase != PH_HALT) stop_error(ERR_MISSING);
         clear_parser();
      end
      if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
      foreach (step_results[k]) expected_results.push_back(step_results[k]);
   endfunction

   always @(posedge clock) begin
      out_item_type want;
      if (reset) begin
         clear_parser();
         expected_results.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result %p", rsp_payload);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_payload !== want) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p, got %p", want, rsp_payload);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_byte(req_payload);
      end
      pending_count <= expected_results.size();
   end

endmodule

[bench/wav_pcm16_stream_to_stereo_tb.sv]
`timescale 1ns / 1ps
module wav_pcm16_stream_to_stereo_tb;
   import wavs_pkg::*;

   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int fail_count;
   int pending_count;
   int idle_cycles = 0;
   logic sending_done = 1'b0;
   logic hold_off = 1'b0;
   int bytes_sent = 0;

   wavs_if #(.payload_type(in_item_type))  req ();
   wavs_if #(.payload_type(out_item_type)) rsp ();

   wav_pcm16_stream_to_stereo u_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   wavs_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready), .req_payload(req.payload),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.payload = '0;
      rsp.ready = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   logic [7:0] file_bytes[$];

   // Sends one byte; gaps drawn per transaction unless running back to back.
   task automatic send_byte(logic [7:0] b, logic eof, logic no_gaps);
      int gap;
      gap = no_gaps ? 0 : (($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 19)) : 0);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.payload <= {b, eof};
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_file(logic no_gaps);
      foreach (file_bytes[i])
         send_byte(file_bytes[i], i == file_bytes.size() - 1, no_gaps);
      file_bytes.delete();
   endtask

   function automatic void add_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) file_bytes.push_back(w[8*i +: 8]);
   endfunction

   function automatic void add_half(logic [15:0] h);
      file_bytes.push_back(h[7:0]);
      file_bytes.push_back(h[15:8]);
   endfunction

   function automatic void add_fmt(logic [31:0] size, logic [15:0] code, logic [15:0] ch,
         logic [31:0] rt, logic [15:0] depth);
      add_word(TAG_FMT);
      add_word(size);
      add_half(code);
      add_half(ch);
      add_word(rt);
      add_word($urandom);
      add_half(16'($urandom));
      add_half(depth);
      for (int i = 16; i < size; i++) file_bytes.push_back(8'($urandom));
   endfunction

   // Builds a file: mostly well formed, with a mode that picks a defect.
   function automatic void build_file(int mode, int n_bytes, logic [15:0] ch);
      int cut;
      add_word(mode == 1 ? $urandom : TAG_RIFF);
      add_word($urandom);
      add_word(mode == 2 ? $urandom : TAG_WAVE);
      if ($urandom_range(0, 2) == 0) begin
         int sz;
         sz = int'($urandom_range(0, 5));
         add_word(32'h5453494c);
         add_word(32'(sz));
         repeat (sz) file_bytes.push_back(8'($urandom));
      end
      if (mode != 3)
         add_fmt($urandom_range(0, 1) ? 32'd16 : 32'($urandom_range(0, 20)),
                 mode == 4 ? 16'($urandom_range(2, 65535)) : 16'd1,
                 mode == 6 ? 16'd0 : ch, $urandom,
                 mode == 5 ? 16'($urandom) : 16'd16);
      add_word(TAG_DATA);
      add_word(32'(n_bytes));
      for (int i = 0; i < n_bytes; i++) file_bytes.push_back(8'($urandom));
      // An early end lands anywhere; a long data size gets cut short too.
      if (mode == 7) begin
         cut = int'($urandom_range(1, file_bytes.size()));
         while (file_bytes.size() > cut) void'(file_bytes.pop_back());
      end
      // Trailing bytes after done or error are ignored.
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
   endfunction

   initial begin
      logic [15:0] ch;
      @(negedge reset);
      @(posedge clock);
      // Directed: empty file byte, bad tags, bad fmt cases, extremes of samples.
      file_bytes.push_back(8'hff);
      send_file(1'b0);
      build_file(0, 0, 16'd1);
      send_file(1'b0);
      add_word(TAG_RIFF); add_word(32'd0); add_word(TAG_WAVE);
      add_fmt(32'd16, 16'd1, 16'd2, 32'hffffffff, 16'd16);
      add_word(TAG_DATA); add_word(32'd9);
      add_half(16'h8000); add_half(16'h7fff); add_half(16'h0000); add_half(16'hffff);
      file_bytes.push_back(8'h55);
      send_file(1'b0);
      for (int m = 1; m <= 6; m++) begin
         build_file(m, 4, 16'd1);
         send_file(1'b0);
      end
      add_word(TAG_RIFF); add_word(32'd0); add_word(TAG_WAVE);
      add_fmt(32'd16, 16'd1, 16'hffff, 32'd0, 16'd16);
      add_fmt(32'd20, 16'd1, 16'd3, 32'd48000, 16'd16);
      add_word(TAG_DATA); add_word(32'hffffffff);
      repeat (13) file_bytes.push_back(8'($urandom));
      send_file(1'b0);
      // Back to back with the receiver holding off, so the block must stall.
      hold_off = 1'b1;
      build_file(0, 40, 16'd1);
      send_file(1'b1);
      hold_off = 1'b0;
      while (bytes_sent < 2000) begin
         ch = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(3, 6))
                                          : 16'($urandom_range(1, 2));
         build_file(($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 7)) : 0,
                    int'($urandom_range(0, 30)), ch);
         send_file(1'($urandom_range(0, 4) == 0));
      end
      req.valid <= 1'b0;
      sending_done = 1'b1;
   end

   // Receiver: random stalls per transaction, plus one long hold.
   initial begin
      int gap;
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_off && !held) begin
            held = 1'b1;
            rsp.ready <= 1'b0;
            repeat (200) @(posedge clock);
         end
         gap = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 19)) : 0;
         if (gap > 0) begin
            rsp.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
         if (sending_done && pending_count == 0) begin
            repeat (20) @(posedge clock);
            if (fail_count == 0 && pending_count == 0) begin
               $display("TEST PASSED");
            end else begin
               $display("TEST FAILED");
            end
            $finish;
         end
      end
   end

endmodule

[wav_pcm16_stream_to_stereo.f]
sv/wavs_pkg.sv
sv/wavs_if.sv
sv/wavs_front.sv
sv/wavs_queue.sv
sv/wavs_back.sv
sv/wav_pcm16_stream_to_stereo.sv
bench/wavs_checker.sv
bench/wav_pcm16_stream_to_stereo_tb.sv
